// ----- hw/rtl/three_digit_seven_segment_scanner_defines.svh -----
`ifndef THREE_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define THREE_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TDSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define TDSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tdss_pkg.sv -----
package tdss_pkg;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] value;
        logic [1:0]         format;
    } t_in_word;

    typedef struct packed {
        logic [1:0] digit_enable;
        logic [6:0] segments;
        logic       decimal_point;
    } t_out_word;

    typedef struct packed {
        logic       neg;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [1:0] format;
    } t_digits;

    typedef struct packed {
        logic    kind;
        t_digits digits;
    } t_split_word;

    typedef struct packed {
        logic       kind;
        logic       neg;
        logic [1:0] format;
    } t_tag;

    typedef struct packed {
        logic [15:0] slot_ticks;
        logic [15:0] gap_ticks;
    } t_cfg;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam logic [1:0] FMT_PLAIN  = 2'd0;
    localparam logic [1:0] FMT_POINT  = 2'd1;
    localparam logic [1:0] FMT_SIGNED = 2'd2;

    localparam logic [1:0] EN_NONE     = 2'd0;
    localparam logic [1:0] EN_HUNDREDS = 2'd1;
    localparam logic [1:0] EN_TENS     = 2'd2;
    localparam logic [1:0] EN_ONES     = 2'd3;

    localparam logic [1:0] SLOT_GAP = 2'd3;

    localparam logic CFG_SLOT_TICKS = 1'b0;
    localparam logic CFG_GAP_TICKS  = 1'b1;

    localparam logic [15:0] SLOT_TICKS_RESET = 16'd1000;
    localparam logic [15:0] GAP_TICKS_RESET  = 16'd0;

    localparam logic [6:0] SEG_MINUS = 7'h40;

    // floor(mag / 1000) estimate, low by at most one for mag up to 32768
    localparam logic [10:0] RECIP_1000  = 11'd1048;
    localparam int          RECIP_SHIFT = 20;
    localparam logic [15:0] K_1000      = 16'd1000;
    // floor(m / 100) for m below 1000
    localparam logic [15:0] RECIP_100   = 16'd41;
    localparam logic [9:0]  K_100       = 10'd100;
    // floor(r / 10) for r below 100
    localparam logic [14:0] RECIP_10    = 15'd205;

    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/tdss_split.sv -----
module tdss_split (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tdss_pkg::t_in_word    i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tdss_pkg::t_split_word o_word
);
    import tdss_pkg::*;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic        w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;

    t_in_word    r_w1;
    t_tag        r_tag2, r_tag3, r_tag4, r_tag5, r_tag6;
    logic [15:0] r_mag2;
    logic [5:0]  r_q2;
    logic [9:0]  r_m3, r_m4;
    logic [3:0]  r_h4, r_h5, r_h6;
    logic [6:0]  r_r5;
    logic [3:0]  r_t6, r_o6;

    t_tag        n_tag2;
    logic [16:0] n_mag;
    logic [26:0] n_prod2;
    logic [15:0] n_qk, n_diff;
    logic [9:0]  n_m;
    logic [15:0] n_prod4;
    logic [9:0]  n_hk, n_rem;
    logic [14:0] n_prod6;
    logic [3:0]  n_tens;
    logic [6:0]  n_tens10, n_ones;

    assign w_rdy6  = !r_v6 || i_ready;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // magnitude and thousands estimate
    always_comb begin
        n_tag2.kind   = r_w1.kind;
        n_tag2.neg    = r_w1.value[15];
        n_tag2.format = r_w1.format;
        n_mag   = r_w1.value[15] ? (17'h10000 - {1'b0, r_w1.value}) : {1'b0, r_w1.value};
        n_prod2 = 27'(n_mag[15:0]) * 27'(RECIP_1000);
    end

    // remainder modulo 1000 with one correction
    always_comb begin
        n_qk   = 16'(r_q2) * K_1000;
        n_diff = r_mag2 - n_qk;
        n_m    = (n_diff >= K_1000) ? 10'(n_diff - K_1000) : n_diff[9:0];
    end

    assign n_prod4 = 16'(r_m3) * RECIP_100;

    always_comb begin
        n_hk  = 10'(r_h4) * K_100;
        n_rem = r_m4 - n_hk;
    end

    always_comb begin
        n_prod6  = 15'(r_r5) * RECIP_10;
        n_tens   = n_prod6[14:11];
        n_tens10 = 7'({n_tens, 3'b000}) + 7'({n_tens, 1'b0});
        n_ones   = r_r5 - n_tens10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_w1 <= i_word;
        end
        if (w_rdy2 && r_v1) begin
            r_tag2 <= n_tag2;
            r_mag2 <= n_mag[15:0];
            r_q2   <= n_prod2[RECIP_SHIFT +: 6];
        end
        if (w_rdy3 && r_v2) begin
            r_tag3 <= r_tag2;
            r_m3   <= n_m;
        end
        if (w_rdy4 && r_v3) begin
            r_tag4 <= r_tag3;
            r_m4   <= r_m3;
            r_h4   <= n_prod4[15:12];
        end
        if (w_rdy5 && r_v4) begin
            r_tag5 <= r_tag4;
            r_h5   <= r_h4;
            r_r5   <= n_rem[6:0];
        end
        if (w_rdy6 && r_v5) begin
            r_tag6 <= r_tag5;
            r_h6   <= r_h5;
            r_t6   <= n_tens;
            r_o6   <= n_ones[3:0];
        end
    end

    assign o_valid              = r_v6;
    assign o_word.kind          = r_tag6.kind;
    assign o_word.digits.neg    = r_tag6.neg;
    assign o_word.digits.format = r_tag6.format;
    assign o_word.digits.hundreds = r_h6;
    assign o_word.digits.tens   = r_t6;
    assign o_word.digits.ones   = r_o6;

endmodule

// ----- hw/rtl/tdss_core.sv -----
module tdss_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tdss_pkg::t_split_word i_word,
    input  tdss_pkg::t_cfg        i_cfg,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tdss_pkg::t_out_word   o_out_word
);
    import tdss_pkg::*;

    localparam logic [1:0] POS_ONES = 2'd0;
    localparam logic [1:0] POS_TENS = 2'd1;

    logic        r_out_valid;
    t_out_word   r_out_word;
    t_digits     r_pending;
    t_digits     r_frame;
    logic [1:0]  r_slot;
    logic [15:0] r_tick;

    logic        w_take, w_minus, w_point;
    logic        n_start;
    t_digits     w_frame;
    logic [1:0]  w_slot, w_blanks, w_pos;
    logic [15:0] w_base;
    logic [16:0] w_inc;
    t_out_word   n_out;
    logic [1:0]  n_slot;
    logic [15:0] n_tick;

    assign o_ready = !r_out_valid || !i_out_stall;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_start = (i_word.kind == KIND_TICK) && (r_slot == SLOT_GAP)
                  && (r_tick >= i_cfg.gap_ticks);
        w_frame = n_start ? r_pending : r_frame;
        w_slot  = n_start ? 2'd0 : r_slot;
        w_minus = (w_frame.format == FMT_SIGNED) && w_frame.neg;
        w_point = (w_frame.format == FMT_POINT) || (w_frame.format == FMT_SIGNED);

        if (w_minus) begin
            w_blanks = 2'd0;
        end else if (w_point) begin
            w_blanks = (w_frame.hundreds == 4'd0) ? 2'd1 : 2'd0;
        end else if (w_frame.hundreds == 4'd0) begin
            w_blanks = (w_frame.tens == 4'd0) ? 2'd2 : 2'd1;
        end else begin
            w_blanks = 2'd0;
        end

        w_pos = w_slot - w_blanks;
        n_out = '0;
        if (w_slot != SLOT_GAP && w_slot >= w_blanks) begin
            case (w_pos)
                POS_ONES: begin
                    n_out.digit_enable = EN_ONES;
                    n_out.segments     = seg_of(w_frame.ones);
                end
                POS_TENS: begin
                    n_out.digit_enable  = EN_TENS;
                    n_out.segments      = seg_of(w_frame.tens);
                    n_out.decimal_point = w_point;
                end
                default: begin
                    n_out.digit_enable = EN_HUNDREDS;
                    n_out.segments     = w_minus ? SEG_MINUS : seg_of(w_frame.hundreds);
                end
            endcase
        end

        w_base = n_start ? 16'd0 : r_tick;
        w_inc  = {1'b0, w_base} + 17'd1;
        if (w_slot != SLOT_GAP && w_inc >= {1'b0, i_cfg.slot_ticks}) begin
            n_slot = w_slot + 2'd1;
            n_tick = 16'd0;
        end else begin
            n_slot = w_slot;
            n_tick = w_inc[16] ? 16'hFFFF : w_inc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_word  <= '0;
            r_pending   <= '0;
            r_frame     <= '0;
            r_slot      <= SLOT_GAP;
            r_tick      <= 16'd0;
        end else begin
            if (o_ready) r_out_valid <= i_valid;
            if (w_take) begin
                r_out_word <= n_out;
                if (i_word.kind == KIND_LOAD) begin
                    r_pending <= i_word.digits;
                end else begin
                    r_frame <= w_frame;
                    r_slot  <= n_slot;
                    r_tick  <= n_tick;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- hw/rtl/three_digit_seven_segment_scanner.sv -----
// Scans a multiplexed three-digit seven-segment display. Every word in gives exactly one
// word out: a tick word advances the scan by one tick and a load word stores a value and
// format that take over at the next frame start; both return the current digit drive.
// A word is taken every cycle unless stalled; it passes the six-stage digit split (magnitude
// modulo 1000 into hundreds, tens and ones) and then the scan state register. Input stall
// rises only while a result is held at the output and every stage is full. Slot and gap
// lengths are written through the config port by the user only while the block is idle;
// the block does not enforce this. Reset loads 1000 and 0. No clearing pass follows reset.
`include "three_digit_seven_segment_scanner_defines.svh"

module three_digit_seven_segment_scanner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tdss_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tdss_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import tdss_pkg::*;

    logic [15:0] r_slot_ticks_q;
    logic [15:0] r_gap_ticks;
    t_cfg        w_cfg;
    logic        w_split_ready, w_split_valid, w_core_ready;
    t_split_word w_split_word;

    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ticks_q <= SLOT_TICKS_RESET;
            r_gap_ticks    <= GAP_TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SLOT_TICKS: r_slot_ticks_q <= i_cfg_data;
                CFG_GAP_TICKS:  r_gap_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.slot_ticks = r_slot_ticks_q;
    assign w_cfg.gap_ticks  = r_gap_ticks;

    tdss_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_split_ready),
        .i_word  (i_in_word),
        .o_valid (w_split_valid),
        .i_ready (w_core_ready),
        .o_word  (w_split_word)
    );

    tdss_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_split_valid),
        .o_ready     (w_core_ready),
        .i_word      (w_split_word),
        .i_cfg       (w_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = !w_split_ready;

    `TDSS_ASSERT_IMP(a_dark_is_blank, o_out_valid && (o_out_word.digit_enable == EN_NONE), (o_out_word.segments == 7'd0) && !o_out_word.decimal_point, "dark slot drives segments")
    `TDSS_ASSERT_IMP(a_point_on_tens, o_out_valid && o_out_word.decimal_point, o_out_word.digit_enable == EN_TENS, "decimal point away from tens")
    `TDSS_ASSERT_IMP(a_stall_only_blocked, o_in_stall, o_out_valid && i_out_stall, "input stalled with output free")
    `TDSS_ASSERT_NXT(a_cfg_slot_write, i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_SLOT_TICKS), r_slot_ticks_q == $past(i_cfg_data), "slot length not written")

endmodule
